// ===== hw/rtl/tile_cache_mark_sweep_top_defines.svh =====
// ---------------------------------------------------------------------------
// Tile cache assertion macros
// Concurrent assertion helpers for the tile cache; they compile away when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TILE_CACHE_MARK_SWEEP_TOP_DEFINES_SVH
`define TILE_CACHE_MARK_SWEEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TCMS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("tile cache assertion failed");
`define TCMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("tile cache assertion failed");
`else
`define TCMS_ASSERT_SAME(label, ante, cons)
`define TCMS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/tcms_pkg.sv =====
// ---------------------------------------------------------------------------
// Tile cache package
// Shared types, field widths and parameter defaults for the tile cache.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcms_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int COORD_BITS_DEF = 20;

    localparam int KIND_W   = 2;
    localparam int LEVEL_W  = 5;
    localparam int TILE_W   = 20;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_START  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_SWEEP  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_HIT      = 3'd1,
        ST_MISS     = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        t_kind               kind;
        logic [LEVEL_W-1:0]  level;
        logic [TILE_W-1:0]   tile_x;
        logic [TILE_W-1:0]   tile_y;
        logic [HANDLE_W-1:0] tile_handle;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] hit_handle;
    } t_result;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctrl;

endpackage

// ===== hw/rtl/tile_cache_mark_sweep_top.sv =====
// ---------------------------------------------------------------------------
// Tile cache with mark-and-sweep replacement
// A table of tile entries for one current zoom level. Each input transaction
// starts an update, inserts a tile, queries a tile or sweeps unused entries,
// and gives exactly one result transaction with a status and a hit handle.
// Both channels use valid and ready. A transaction is registered on accept,
// applied to the table against all entries at once when the result stage
// can take it, and its result is registered in the result stage before it
// is offered. One transaction per cycle is sustained while the receiver
// takes results; the table does its key compare over all entries and its
// mark update in one combinational step, registered on each advance.
// The result register frees as it is read, so the block takes a new input
// in the same cycle that the receiver takes a result. When the receiver
// stalls, the result holds, the table stalls, and one more input can still
// be held in the input register before ready falls.
// Reset clears all valid and used marks, the current level and the valid
// flags of both pipeline registers; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tile_cache_mark_sweep_top_defines.svh"

module tile_cache_mark_sweep_top #(
    parameter int ENTRIES    = tcms_pkg::ENTRIES_DEF,
    parameter int COORD_BITS = tcms_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tcms_pkg::KIND_W-1:0]    i_kind,
    input  logic [tcms_pkg::LEVEL_W-1:0]   i_level,
    input  logic [tcms_pkg::TILE_W-1:0]    i_tile_x,
    input  logic [tcms_pkg::TILE_W-1:0]    i_tile_y,
    input  logic [tcms_pkg::HANDLE_W-1:0]  i_tile_handle,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tcms_pkg::STATUS_W-1:0]  o_status,
    output logic [tcms_pkg::HANDLE_W-1:0]  o_hit_handle
);
    import tcms_pkg::*;

    t_item              w_in_item;
    t_item              w_item;
    t_stage_ctrl        w_ctrl;
    t_result            w_tbl_result;
    t_result            w_out_result;
    logic               w_advance;
    logic [ENTRIES-1:0] w_match;

    assign w_in_item.kind        = t_kind'(i_kind);
    assign w_in_item.level       = i_level;
    assign w_in_item.tile_x      = i_tile_x;
    assign w_in_item.tile_y      = i_tile_y;
    assign w_in_item.tile_handle = i_tile_handle;

    tcms_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (w_in_item),
        .i_advance  (w_advance),
        .o_ctrl     (w_ctrl),
        .o_item     (w_item)
    );

    tcms_table #(
        .ENTRIES    (ENTRIES),
        .COORD_BITS (COORD_BITS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_item   (w_item),
        .o_result (w_tbl_result),
        .o_match  (w_match)
    );

    tcms_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_result    (w_tbl_result),
        .o_advance   (w_advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_out_result)
    );

    assign o_status     = w_out_result.status;
    assign o_hit_handle = w_out_result.hit_handle;

    `TCMS_ASSERT_SAME(a_key_unique, w_ctrl.valid, $onehot0(w_match))
    `TCMS_ASSERT_NEXT(a_result_follows, w_ctrl.advance, o_out_valid)
    `TCMS_ASSERT_SAME(a_handle_zero, o_out_valid && (o_status != ST_HIT), o_hit_handle == '0)

endmodule

// ===== hw/rtl/tcms_in_stage.sv =====
// ---------------------------------------------------------------------------
// Tile cache input stage
// Registers one incoming transaction and holds it until the table consumes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcms_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tcms_pkg::t_item      i_item,
    input  logic                 i_advance,
    output tcms_pkg::t_stage_ctrl o_ctrl,
    output tcms_pkg::t_item      o_item
);
    import tcms_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign o_in_ready = !r_valid || i_advance;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_ctrl.valid   = r_valid;
    assign o_ctrl.advance = r_valid && i_advance;
    assign o_item         = r_item;

endmodule

// ===== hw/rtl/tcms_table.sv =====
// ---------------------------------------------------------------------------
// Tile cache entry table
// Holds all entries with their marks, compares every key in parallel and
// applies one transaction per cycle while the result stage is not stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcms_table #(
    parameter int ENTRIES    = tcms_pkg::ENTRIES_DEF,
    parameter int COORD_BITS = tcms_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcms_pkg::t_stage_ctrl i_ctrl,
    input  tcms_pkg::t_item       i_item,
    output tcms_pkg::t_result     o_result,
    output logic [ENTRIES-1:0]    o_match
);
    import tcms_pkg::*;

    localparam int KEY_W = 2 * COORD_BITS;

    logic [ENTRIES-1:0]  r_valid;
    logic [ENTRIES-1:0]  r_used;
    logic [LEVEL_W-1:0]  r_level;
    logic                r_known;
    logic [KEY_W-1:0]    r_key    [ENTRIES];
    logic [HANDLE_W-1:0] r_handle [ENTRIES];

    logic [ENTRIES-1:0]  n_valid;
    logic [ENTRIES-1:0]  n_used;
    logic [LEVEL_W-1:0]  n_level;
    logic                n_known;

    logic [KEY_W-1:0]    w_key;
    logic                w_level_ok;
    logic [ENTRIES-1:0]  w_match;
    logic                w_any;
    logic [ENTRIES-1:0]  w_free;
    logic [ENTRIES-1:0]  w_free_low;
    logic [ENTRIES-1:0]  w_sel;
    logic [ENTRIES-1:0]  w_wr;
    logic [HANDLE_W-1:0] w_handle;

    assign w_key      = {COORD_BITS'(i_item.tile_x), COORD_BITS'(i_item.tile_y)};
    assign w_level_ok = r_known && (i_item.level == r_level);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == w_key);
        end
    end

    always_comb begin
        w_handle = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_handle = w_handle | (r_handle[i] & {HANDLE_W{w_match[i]}});
        end
    end

    assign w_any      = |w_match;
    assign w_free     = ~r_valid;
    assign w_free_low = w_free & ((~w_free) + ENTRIES'(1));
    assign w_sel      = w_any ? w_match : w_free_low;

    always_comb begin
        n_valid             = r_valid;
        n_used              = r_used;
        n_level             = r_level;
        n_known             = r_known;
        w_wr                = '0;
        o_result.status     = ST_DONE;
        o_result.hit_handle = '0;
        unique case (i_item.kind)
            KIND_START: begin
                if (!w_level_ok) begin
                    n_level = i_item.level;
                    n_known = 1'b1;
                    n_valid = '0;
                end
                n_used = '0;
            end
            KIND_INSERT: begin
                if (!r_known) begin
                    o_result.status = ST_MISMATCH;
                end else if (w_sel == '0) begin
                    o_result.status = ST_FULL;
                end else begin
                    w_wr    = w_sel;
                    n_valid = r_valid | w_sel;
                    n_used  = r_used & ~w_sel;
                end
            end
            KIND_QUERY: begin
                if (!w_level_ok) begin
                    o_result.status = ST_MISMATCH;
                end else if (w_any) begin
                    o_result.status     = ST_HIT;
                    o_result.hit_handle = w_handle;
                    n_used              = r_used | w_match;
                end else begin
                    o_result.status = ST_MISS;
                end
            end
            KIND_SWEEP: begin
                if (!w_level_ok) begin
                    o_result.status = ST_MISMATCH;
                end else begin
                    n_valid = r_valid & r_used;
                end
            end
            default: begin
                o_result.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            r_level <= '0;
            r_known <= 1'b0;
        end else if (i_ctrl.advance) begin
            r_valid <= n_valid;
            r_used  <= n_used;
            r_level <= n_level;
            r_known <= n_known;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_ctrl.advance && w_wr[i]) begin
                r_key[i]    <= w_key;
                r_handle[i] <= i_item.tile_handle;
            end
        end
    end

    assign o_match = w_match;

endmodule

// ===== hw/rtl/tcms_out_stage.sv =====
// ---------------------------------------------------------------------------
// Tile cache result stage
// Holds one finished result until the receiver takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcms_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcms_pkg::t_stage_ctrl i_ctrl,
    input  tcms_pkg::t_result     i_result,
    output logic                  o_advance,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tcms_pkg::t_result     o_result
);
    import tcms_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.advance) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.advance) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule
